// ----- hdl/mep_pkg.sv -----
// Shared types, constants and helpers for the Mandelbrot escape-time pixel block.
// No dependencies; imported by every module under hdl.
`default_nettype none

package mep_pkg;

  localparam int unsigned PIX_W     = 9;
  localparam int unsigned ITER_W    = 10;
  localparam int unsigned COLOR_W   = 32;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned SPAN_W    = 31;
  localparam int unsigned CFG_IDX_W = 2;

  // View is 512 pixels across: r*2*idx/512 is (r*idx) >> 8.
  localparam int unsigned MAP_SHIFT = 8;

  localparam logic [SPAN_W-1:0]  SPAN_RESET   = 31'd536870912;
  localparam logic [31:0]        ESCAPE_LIMIT = 32'h4000_0000;
  localparam logic [30:0]        SQ_SAT       = 31'h7FFF_FFFF;
  localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 32'hFF00_0000;
  localparam logic [5:0]         HUE_M_LAST   = 6'd59;
  localparam logic [2:0]         SECTOR_LAST  = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_RE = 2'd0,
    CFG_CENTER_IM = 2'd1,
    CFG_HALF_SPAN = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    MUL_MAP  = 1'b0,
    MUL_ITER = 1'b1
  } mul_sel_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;
  } in_beat_t;

  typedef struct packed {
    logic [ITER_W-1:0]  iter_count;
    logic [COLOR_W-1:0] pixel_color;
  } out_beat_t;

  // Control from the sequencer to the arithmetic unit.
  typedef struct packed {
    mul_sel_e mul_sel;
    logic     mul_en;
    logic     set_c;
    logic     upd_z;
  } step_ctrl_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/mep_step_unit.sv -----
// Shared multiply unit with product registers, point mapping and z update.
// Depends on mep_pkg (step_ctrl_t, sat32, constants).
`default_nettype none

module mep_step_unit
  import mep_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire step_ctrl_t               ctrl_i,
  input  wire logic signed [DATA_W-1:0] center_re_i,
  input  wire logic signed [DATA_W-1:0] center_im_i,
  input  wire logic [SPAN_W-1:0]        half_span_i,
  input  wire in_beat_t                 pix_i,
  output logic                          escape_o
);

  logic signed [DATA_W-1:0] x_q, y_q, u_q, v_q;
  logic signed [DATA_W-1:0] x_d, y_d, u_d, v_d;
  logic signed [DATA_W-1:0] a0, b0, a1, b1;
  logic signed [63:0]       pa_q, pb_q, pc_q;
  logic signed [63:0]       pa_d, pb_d, pc_d;
  logic signed [63:0]       span64;
  logic [30:0]              sq_x, sq_y;
  logic [31:0]              mag;

  // Operand select: pixel mapping uses r*col and r*row, iteration uses x*x, y*y, x*y.
  always_comb begin
    case (ctrl_i.mul_sel)
      MUL_MAP: begin
        a0 = $signed({1'b0, half_span_i});
        b0 = $signed({{(DATA_W-PIX_W){1'b0}}, pix_i.pixel_col});
        a1 = $signed({1'b0, half_span_i});
        b1 = $signed({{(DATA_W-PIX_W){1'b0}}, pix_i.pixel_row});
      end
      default: begin
        a0 = x_q;
        b0 = x_q;
        a1 = y_q;
        b1 = y_q;
      end
    endcase
  end

  assign pa_d = 64'(a0) * 64'(b0);
  assign pb_d = 64'(a1) * 64'(b1);
  assign pc_d = 64'(x_q) * 64'(y_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
      pc_q <= pc_d;
    end
  end

  // Squares are non-negative; saturate the Q4.28 result to 31 bits.
  assign sq_x = (pa_q[62:59] != 4'd0) ? SQ_SAT : pa_q[58:28];
  assign sq_y = (pb_q[62:59] != 4'd0) ? SQ_SAT : pb_q[58:28];
  assign mag  = {1'b0, sq_x} + {1'b0, sq_y};
  assign escape_o = (mag > ESCAPE_LIMIT);

  assign span64 = $signed({33'd0, half_span_i});

  always_comb begin
    u_d = sat32(64'(center_re_i) - span64 + (pa_q >>> MAP_SHIFT));
    v_d = sat32(64'(center_im_i) + span64 - (pb_q >>> MAP_SHIFT));
    x_d = sat32($signed({33'd0, sq_x}) - $signed({33'd0, sq_y}) + 64'(u_q));
    y_d = sat32((pc_q >>> 27) + 64'(v_q));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.set_c) begin
      u_q <= u_d;
      v_q <= v_d;
      x_q <= '0;
      y_q <= '0;
    end else if (ctrl_i.upd_z) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mep_hue_color.sv -----
// Full-saturation HSV to ARGB colour from hue sector and offset within it.
// Depends on mep_pkg (widths, alpha constant).
`default_nettype none

module mep_hue_color
  import mep_pkg::*;
(
  input  wire logic [2:0]   sector_i,
  input  wire logic [5:0]   hue_m_i,
  input  wire logic         black_i,
  output logic [COLOR_W-1:0] color_o
);

  logic [9:0] t_mul, q_mul;
  logic [5:0] m_rev;
  logic [7:0] t, q, r, g, b;

  // 255/60 = 17/4, so floor scaling is a multiply by 17 and a shift.
  assign m_rev = 6'd60 - hue_m_i;
  assign t_mul = 10'({hue_m_i, 4'd0}) + 10'(hue_m_i);
  assign q_mul = 10'({m_rev, 4'd0}) + 10'(m_rev);
  assign t     = t_mul[9:2];
  assign q     = q_mul[9:2];

  always_comb begin
    case (sector_i)
      3'd0:    begin r = 8'hFF; g = t;     b = 8'h00; end
      3'd1:    begin r = q;     g = 8'hFF; b = 8'h00; end
      3'd2:    begin r = 8'h00; g = 8'hFF; b = t;     end
      3'd3:    begin r = 8'h00; g = q;     b = 8'hFF; end
      3'd4:    begin r = t;     g = 8'h00; b = 8'hFF; end
      default: begin r = 8'hFF; g = 8'h00; b = q;     end
    endcase
  end

  assign color_o = black_i ? ALPHA_OPAQUE : (ALPHA_OPAQUE | {8'h00, r, g, b});

endmodule

`default_nettype wire

// ----- hdl/mandelbrot_escape_pixel.sv -----
// Top level of the Mandelbrot escape-time pixel block: config registers, sequencer,
// output register. Depends on mep_pkg, mep_step_unit and mep_hue_color.
`default_nettype none

// Channel   Direction  Handshake               Beat
// in        input      in_valid_i / in_stall_o  in_beat_t  (pixel_col, pixel_row)
// out       output     out_valid_o / out_stall_i out_beat_t (iter_count, pixel_color)
// cfg       input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// An accepted pixel runs through S_MAP_MUL and S_MAP_SET, then S_MUL and S_UPD once per
// step (the step count, held in cnt, reaches at most MAX_ITER), then S_FIN, which waits
// for the output register to drain. Each step uses the shared multiply unit: S_MUL
// registers x*x, y*y and x*y, S_UPD tests the escape bound and writes back z. Mapping
// the pixel reuses the same multipliers in S_MAP_MUL. Reset is asynchronous and active
// low; it clears the sequencer and output valid and loads the configuration reset values.
// A new beat is taken while a finished result still waits on a stalled output.

module mandelbrot_escape_pixel
  import mep_pkg::*;
#(
  parameter int unsigned MAX_ITER = 1023
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire in_beat_t          in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_beat_t              out_data_o,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned CNT_W = $clog2(MAX_ITER + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITER);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_MAP_MUL = 6'b000010,
    S_MAP_SET = 6'b000100,
    S_MUL     = 6'b001000,
    S_UPD     = 6'b010000,
    S_FIN     = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic signed [DATA_W-1:0] center_re_q, center_im_q;
  logic [SPAN_W-1:0]        half_span_q;

  in_beat_t          pix_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [5:0]        hue_m_q, hue_m_d;
  logic [2:0]        sector_q, sector_d;
  logic              out_valid_q, out_valid_d;
  out_beat_t         out_q;
  logic              out_load;
  logic              out_free;
  logic              in_take;
  logic              escape;
  logic              never_escaped;
  logic [COLOR_W-1:0] color;
  step_ctrl_t        ctrl;

  // Configuration writes: index beyond the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_re_q <= '0;
      center_im_q <= '0;
      half_span_q <= SPAN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_CENTER_RE: center_re_q <= $signed(cfg_wdata_i);
        CFG_CENTER_IM: center_im_q <= $signed(cfg_wdata_i);
        CFG_HALF_SPAN: half_span_q <= cfg_wdata_i[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Hold the pixel while it is mapped.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pix_q <= in_data_i;
    end
  end

  // Sequencer: map the pixel, then alternate multiply and update until escape or limit.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    hue_m_d      = hue_m_q;
    sector_d     = sector_q;
    ctrl.mul_sel = MUL_ITER;
    ctrl.mul_en  = 1'b0;
    ctrl.set_c   = 1'b0;
    ctrl.upd_z   = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_MAP_MUL;
        end
      end
      S_MAP_MUL: begin
        ctrl.mul_sel = MUL_MAP;
        ctrl.mul_en  = 1'b1;
        state_d      = S_MAP_SET;
      end
      S_MAP_SET: begin
        ctrl.set_c = 1'b1;
        cnt_d      = '0;
        hue_m_d    = '0;
        sector_d   = '0;
        state_d    = S_MUL;
      end
      S_MUL: begin
        ctrl.mul_en = 1'b1;
        state_d     = S_UPD;
      end
      S_UPD: begin
        if (cnt_q == CNT_MAX || escape) begin
          state_d = S_FIN;
        end else begin
          ctrl.upd_z = 1'b1;
          cnt_d      = cnt_q + 1'b1;
          // Advance hue = count mod 360 as sector*60 + offset.
          if (hue_m_q == HUE_M_LAST) begin
            hue_m_d  = '0;
            sector_d = (sector_q == SECTOR_LAST) ? 3'd0 : sector_q + 3'd1;
          end else begin
            hue_m_d  = hue_m_q + 6'd1;
          end
          state_d = S_MUL;
        end
      end
      S_FIN: begin
        // Wait for the output register to drain before loading.
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    hue_m_q  <= hue_m_d;
    sector_q <= sector_d;
  end

  mep_step_unit u_step (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .center_re_i (center_re_q),
    .center_im_i (center_im_q),
    .half_span_i (half_span_q),
    .pix_i       (pix_q),
    .escape_o    (escape)
  );

  assign never_escaped = (cnt_q == CNT_MAX);

  mep_hue_color u_color (
    .sector_i (sector_q),
    .hue_m_i  (hue_m_q),
    .black_i  (never_escaped),
    .color_o  (color)
  );

  // Output register: set on load, drop once the beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.iter_count  <= ITER_W'(cnt_q);
      out_q.pixel_color <= color;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
